>>> rtl/core/nps_pkg.sv
package nps_pkg;

    // Job store geometry
    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = IDX_W + 1;

    // Field widths
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 10;
    localparam int PRI_W  = 8;
    localparam int TIME_W = 17;

    // One stored job: priority, burst and arrival, arrival in the lowest bits
    localparam int JOB_W = ARR_W + BUR_W + PRI_W;

    // Stream payload widths, padded to whole bytes
    localparam int IN_W      = JOB_W;
    localparam int IN_BYTES  = (IN_W + 7) / 8;
    localparam int OUT_W     = IDX_W + 3 * TIME_W;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;

    // Controller states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_TURN,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/core/nps_ram.sv
module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/nonpreemptive_priority_scheduler_top.sv
// Channel   Direction  Payload
// s_axis    in         tdata: arrival_time, burst_length, priority_level; tlast: last_job
// m_axis    out        tdata: job_index, finish_tick, turnaround, waiting; tlast: last_result
//
// Jobs load one per cycle into the job memory. After the last job the block runs
// one selection pass per scheduling decision: a pass reads every loaded job once
// through the registered memory read port, and a decision that issues a result
// then computes the result fields and waits in the emit state until the output
// accepts it. An idle gap costs one extra pass and one extra decision. The input
// is not ready while a run is in progress.
// Reset (rst_n, asynchronous, active low) clears all counters and done flags.
module nonpreemptive_priority_scheduler_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // arrival_time[15:0], burst_length[25:16], priority_level[33:26], zero pad
    input  logic [nps_pkg::IN_BYTES*8-1:0]     s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // job_index, finish_tick, turnaround, waiting (lowest bit up), zero pad
    output logic [nps_pkg::OUT_BYTES*8-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);

    nps_pkg::state_t state_reg, state_next;

    logic [nps_pkg::CNT_W-1:0]  job_cnt_reg;
    logic [nps_pkg::CNT_W-1:0]  done_cnt_reg;
    logic [nps_pkg::CNT_W-1:0]  iss_reg;
    logic [nps_pkg::MAX_JOBS-1:0] done_reg;
    logic [nps_pkg::TIME_W-1:0] time_reg;

    logic                       cmp_vld_reg;
    logic [nps_pkg::IDX_W-1:0]  cmp_idx_reg;

    logic                       best_vld_reg;
    logic [nps_pkg::IDX_W-1:0]  best_idx_reg;
    logic [nps_pkg::PRI_W-1:0]  best_pri_reg;
    logic [nps_pkg::ARR_W-1:0]  best_arr_reg;
    logic [nps_pkg::BUR_W-1:0]  best_bur_reg;
    logic [nps_pkg::ARR_W-1:0]  min_arr_reg;

    logic [nps_pkg::IDX_W-1:0]  out_idx_reg;
    logic [nps_pkg::TIME_W-1:0] out_fin_reg;
    logic [nps_pkg::TIME_W-1:0] out_turn_reg;
    logic [nps_pkg::TIME_W-1:0] out_wait_reg;
    logic                       out_last_reg;

    logic                       in_acc;
    logic                       out_acc;
    logic                       ram_we;
    logic                       issuing;
    logic                       scan_start;
    logic                       scan_end;
    logic [nps_pkg::JOB_W-1:0]  rd_job;
    logic [nps_pkg::ARR_W-1:0]  rd_arr;
    logic [nps_pkg::BUR_W-1:0]  rd_bur;
    logic [nps_pkg::PRI_W-1:0]  rd_pri;
    logic                       rd_undone;
    logic                       rd_elig;
    logic                       rd_better;

    // Job memory: one word per job
    nps_ram #(
        .WIDTH (nps_pkg::JOB_W),
        .DEPTH (nps_pkg::MAX_JOBS)
    ) u_job_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (job_cnt_reg[nps_pkg::IDX_W-1:0]),
        .wdata (s_axis_tdata[nps_pkg::JOB_W-1:0]),
        .raddr (iss_reg[nps_pkg::IDX_W-1:0]),
        .rdata (rd_job)
    );

    assign rd_arr = rd_job[nps_pkg::ARR_W-1:0];
    assign rd_bur = rd_job[nps_pkg::ARR_W +: nps_pkg::BUR_W];
    assign rd_pri = rd_job[nps_pkg::ARR_W + nps_pkg::BUR_W +: nps_pkg::PRI_W];

    // Compare stage: eligibility and ranking against the best job so far
    assign rd_undone = !done_reg[cmp_idx_reg];
    assign rd_elig   = rd_undone && ({1'b0, rd_arr} <= time_reg);
    assign rd_better = !best_vld_reg || (rd_pri > best_pri_reg)
                       || ((rd_pri == best_pri_reg) && (rd_arr < best_arr_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nps_pkg::ST_LOAD:
            begin
                if (in_acc && s_axis_tlast)
                begin
                    state_next = nps_pkg::ST_SCAN;
                end
            end
            nps_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = nps_pkg::ST_DECIDE;
                end
            end
            nps_pkg::ST_DECIDE:
            begin
                state_next = best_vld_reg ? nps_pkg::ST_TURN : nps_pkg::ST_SCAN;
            end
            nps_pkg::ST_TURN:
            begin
                state_next = nps_pkg::ST_EMIT;
            end
            nps_pkg::ST_EMIT:
            begin
                if (out_acc)
                begin
                    state_next = out_last_reg ? nps_pkg::ST_LOAD : nps_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = nps_pkg::ST_LOAD;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_axis_tready = (state_reg == nps_pkg::ST_LOAD);
        m_axis_tvalid = (state_reg == nps_pkg::ST_EMIT);
        in_acc        = s_axis_tvalid && s_axis_tready;
        out_acc       = m_axis_tvalid && m_axis_tready;
        ram_we        = in_acc && (job_cnt_reg < nps_pkg::CNT_W'(nps_pkg::MAX_JOBS));
        issuing       = (state_reg == nps_pkg::ST_SCAN) && (iss_reg < job_cnt_reg);
        scan_end      = (state_reg == nps_pkg::ST_SCAN) && (iss_reg == job_cnt_reg)
                        && !cmp_vld_reg;
        scan_start    = (in_acc && s_axis_tlast)
                        || ((state_reg == nps_pkg::ST_DECIDE) && !best_vld_reg)
                        || (out_acc && !out_last_reg);
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= nps_pkg::ST_LOAD;
            job_cnt_reg  <= '0;
            done_cnt_reg <= '0;
            done_reg     <= '0;
            time_reg     <= '0;
            iss_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            best_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= issuing;

            if (ram_we)
            begin
                job_cnt_reg <= job_cnt_reg + 1'b1;
            end

            // Scan pointer and best-candidate flag
            if (scan_start)
            begin
                iss_reg      <= '0;
                best_vld_reg <= 1'b0;
            end
            else
            begin
                if (issuing)
                begin
                    iss_reg <= iss_reg + 1'b1;
                end
                if (cmp_vld_reg && rd_elig && rd_better)
                begin
                    best_vld_reg <= 1'b1;
                end
            end

            // Scheduling decision: run the best job, or jump over an idle gap
            if (state_reg == nps_pkg::ST_DECIDE)
            begin
                if (best_vld_reg)
                begin
                    time_reg              <= time_reg + nps_pkg::TIME_W'(best_bur_reg);
                    done_reg[best_idx_reg] <= 1'b1;
                    done_cnt_reg          <= done_cnt_reg + 1'b1;
                end
                else
                begin
                    time_reg <= nps_pkg::TIME_W'(min_arr_reg);
                end
            end

            // End of run: ready for a new job set
            if (out_acc && out_last_reg)
            begin
                job_cnt_reg  <= '0;
                done_cnt_reg <= '0;
                done_reg     <= '0;
                time_reg     <= '0;
            end
        end
    end

    // Candidate payload and result registers
    always_ff @(posedge clk)
    begin
        if (scan_start)
        begin
            min_arr_reg <= '1;
        end
        else if (cmp_vld_reg)
        begin
            if (rd_elig && rd_better)
            begin
                best_idx_reg <= cmp_idx_reg;
                best_pri_reg <= rd_pri;
                best_arr_reg <= rd_arr;
                best_bur_reg <= rd_bur;
            end
            if (rd_undone && (rd_arr < min_arr_reg))
            begin
                min_arr_reg <= rd_arr;
            end
        end
        cmp_idx_reg <= iss_reg[nps_pkg::IDX_W-1:0];

        if ((state_reg == nps_pkg::ST_DECIDE) && best_vld_reg)
        begin
            out_idx_reg  <= best_idx_reg;
            out_fin_reg  <= time_reg + nps_pkg::TIME_W'(best_bur_reg);
            out_wait_reg <= time_reg - nps_pkg::TIME_W'(best_arr_reg);
            out_last_reg <= ((done_cnt_reg + 1'b1) == job_cnt_reg);
        end
        if (state_reg == nps_pkg::ST_TURN)
        begin
            out_turn_reg <= out_fin_reg - nps_pkg::TIME_W'(best_arr_reg);
        end
    end

    assign m_axis_tdata = {{(nps_pkg::OUT_BYTES*8 - nps_pkg::OUT_W){1'b0}},
                           out_wait_reg, out_turn_reg, out_fin_reg, out_idx_reg};
    assign m_axis_tlast = out_last_reg;

    // The completed count never passes the loaded count
    assert property (@(posedge clk) disable iff (!rst_n)
        done_cnt_reg <= job_cnt_reg)
        else $error("completed jobs exceed loaded jobs");

    // Loading and result delivery never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // The final result of a run returns the block to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block did not return to loading after the run");

    // A result is only issued for a job not yet completed
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == nps_pkg::ST_DECIDE) && best_vld_reg) |-> !done_reg[best_idx_reg])
        else $error("job selected twice");

endmodule
